// ===== rtl/sgt_pkg.sv =====
// ----------------------------------------------------------------------------
// sgt_pkg: shared types and constants for the slot grid table
// Command codes, register indexes, request/result structs, sequencer states.
// ----------------------------------------------------------------------------
package sgt_pkg;

    // fixed field widths
    localparam int CMD_W     = 3;
    localparam int HANDLE_W  = 16;
    localparam int POS_W     = 3;
    localparam int GEOM_W    = 4;
    localparam int CFG_IDX_W = 1;

    // defaults for the top-level parameters
    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_HANDLE_BITS = 16;

    // geometry register reset values
    localparam logic [GEOM_W-1:0] ROWS_RST = 4'd2;
    localparam logic [GEOM_W-1:0] COLS_RST = 4'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    src_row;
        logic [POS_W-1:0]    src_col;
        logic [POS_W-1:0]    dst_row;
        logic [POS_W-1:0]    dst_col;
    } t_cmd;

    typedef struct packed {
        logic                ok;
        logic [POS_W-1:0]    slot_row;
        logic [POS_W-1:0]    slot_col;
        logic [HANDLE_W-1:0] slot_handle;
    } t_res;

    // effective (saturated) active area
    typedef struct packed {
        logic [GEOM_W-1:0] rows;
        logic [GEOM_W-1:0] cols;
    } t_geom;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_SRC,
        ST_SRC_DATA,
        ST_DST_DATA,
        ST_MV_WA,
        ST_CP_SCAN,
        ST_CP_ZERO,
        ST_CLR,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/slot_grid_table.sv =====
// ----------------------------------------------------------------------------
// slot_grid_table: grid of item slots with add/remove/move/compact/read/clear
// Slot handles live in one dual-port RAM; a sequencer walks it per command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | request   | i_in_valid / o_in_stall  | command, handle, src/dst row/col
//  out     | result    | o_out_valid / i_out_stall| ok, slot_row, slot_col, slot_handle
//  cfg     | write     | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// One request at a time; N = MAX_ROWS*MAX_COLS.
// After reset a clearing pass zeroes all N table entries with o_in_stall high.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module slot_grid_table #(
    parameter int MAX_ROWS    = sgt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = sgt_pkg::DEF_MAX_COLS,
    parameter int HANDLE_BITS = sgt_pkg::DEF_HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sgt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sgt_pkg::GEOM_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sgt_pkg::CMD_W-1:0]     i_command,
    input  logic [sgt_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [sgt_pkg::POS_W-1:0]     i_src_row,
    input  logic [sgt_pkg::POS_W-1:0]     i_src_col,
    input  logic [sgt_pkg::POS_W-1:0]     i_dst_row,
    input  logic [sgt_pkg::POS_W-1:0]     i_dst_col,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [sgt_pkg::POS_W-1:0]     o_slot_row,
    output logic [sgt_pkg::POS_W-1:0]     o_slot_col,
    output logic [sgt_pkg::HANDLE_W-1:0]  o_slot_handle
);

    import sgt_pkg::*;

    localparam int SLOTS = MAX_ROWS * MAX_COLS;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [GEOM_W-1:0] r_rows, r_cols;
    t_geom             w_geom;
    t_cmd              w_req;
    t_res              w_res, r_out;
    logic              w_res_valid, w_out_free, w_busy;
    logic              r_out_valid;

    logic                   w_mem_we;
    logic [AW-1:0]          w_mem_waddr, w_mem_raddr;
    logic [HANDLE_BITS-1:0] w_mem_wdata, w_mem_rdata;

    // geometry registers, raw value kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RST;
            r_cols <= COLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_wdata;
                CFG_COLS: r_cols <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturate to 1..MAX
    always_comb begin
        w_geom.rows = r_rows;
        w_geom.cols = r_cols;
        if (r_rows == '0) w_geom.rows = 4'd1;
        else if (int'(r_rows) > MAX_ROWS) w_geom.rows = GEOM_W'(MAX_ROWS);
        if (r_cols == '0) w_geom.cols = 4'd1;
        else if (int'(r_cols) > MAX_COLS) w_geom.cols = GEOM_W'(MAX_COLS);
    end

    assign w_req.command = i_command;
    assign w_req.handle  = i_handle;
    assign w_req.src_row = i_src_row;
    assign w_req.src_col = i_src_col;
    assign w_req.dst_row = i_dst_row;
    assign w_req.dst_col = i_dst_col;

    sgt_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    sgt_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_busy      (w_busy),
        .i_req       (w_req),
        .i_geom      (w_geom),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_out_free),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) r_out <= w_res;
    end

    assign o_in_stall    = w_busy;
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out.ok;
    assign o_slot_row    = r_out.slot_row;
    assign o_slot_col    = r_out.slot_col;
    assign o_slot_handle = r_out.slot_handle;

    // table is being cleared right after reset
    a_init_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_in_stall)
        else $error("request taken during clearing pass");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in process");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_slot_row == '0 && o_slot_col == '0
                                 && o_slot_handle == '0)
        else $error("failed result carries nonzero fields");

    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_handle != '0 |-> o_ok)
        else $error("handle returned without success");

endmodule

// ===== rtl/sgt_ram.sv =====
// ----------------------------------------------------------------------------
// sgt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgt_ctrl: command sequencer for the slot grid table
// Walks the slot memory one read per cycle, does the read-modify-write of
// each command and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module sgt_ctrl #(
    parameter int MAX_ROWS    = sgt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = sgt_pkg::DEF_MAX_COLS,
    parameter int HANDLE_BITS = sgt_pkg::DEF_HANDLE_BITS,
    localparam int SLOTS = MAX_ROWS * MAX_COLS,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_busy,
    input  sgt_pkg::t_cmd          i_req,
    input  sgt_pkg::t_geom         i_geom,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output sgt_pkg::t_res          o_res,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [HANDLE_BITS-1:0] o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  logic [HANDLE_BITS-1:0] i_mem_rdata
);

    import sgt_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_res   r_res, n_res;

    // read cursor, position of the data returning this cycle, write cursor
    logic [GEOM_W-1:0] r_row, n_row, r_col, n_col;
    logic              r_end, n_end;
    logic              r_dv, n_dv;
    logic [GEOM_W-1:0] r_prow, n_prow, r_pcol, n_pcol;
    logic [GEOM_W-1:0] r_wrow, n_wrow, r_wcol, n_wcol;
    logic              r_wend, n_wend;
    logic [AW-1:0]     r_lin, n_lin;
    logic [HANDLE_BITS-1:0] r_va, n_va;

    logic [HANDLE_BITS-1:0] w_h;
    logic w_rd_zero;
    logic w_rcol_wrap, w_rrow_last, w_wcol_wrap, w_wrow_last;
    logic w_src_in, w_dst_in, w_req_src_in, w_req_dst_in;

    function automatic logic [AW-1:0] slot_addr(logic [GEOM_W-1:0] row,
                                                logic [GEOM_W-1:0] col);
        slot_addr = AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    function automatic logic in_area(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                     t_geom geom);
        in_area = ({1'b0, row} < geom.rows) && ({1'b0, col} < geom.cols);
    endfunction

    assign w_h         = HANDLE_BITS'({{HANDLE_BITS{1'b0}}, r_cmd.handle});
    assign w_rd_zero   = (i_mem_rdata == '0);
    assign w_rcol_wrap = (r_col + 4'd1 == i_geom.cols);
    assign w_rrow_last = (r_row + 4'd1 == i_geom.rows);
    assign w_wcol_wrap = (r_wcol + 4'd1 == i_geom.cols);
    assign w_wrow_last = (r_wrow + 4'd1 == i_geom.rows);
    assign w_src_in    = in_area(r_cmd.src_row, r_cmd.src_col, i_geom);
    assign w_dst_in    = in_area(r_cmd.dst_row, r_cmd.dst_col, i_geom);
    assign w_req_src_in = in_area(i_req.src_row, i_req.src_col, i_geom);
    assign w_req_dst_in = in_area(i_req.dst_row, i_req.dst_col, i_geom);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_lin == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.command)
                        CMD_ADD: n_state = ST_ADD;
                        CMD_REMOVE, CMD_READ: n_state = w_req_src_in ? ST_SRC : ST_FIN;
                        CMD_MOVE: begin
                            n_state = (w_req_src_in && w_req_dst_in) ? ST_SRC : ST_FIN;
                        end
                        CMD_COMPACT: n_state = ST_CP_SCAN;
                        CMD_CLEAR: n_state = ST_CLR;
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_ADD: begin
                if (w_h == '0 || (r_dv && w_rd_zero) || (!r_dv && r_end)) begin
                    n_state = ST_FIN;
                end
            end
            ST_SRC: n_state = ST_SRC_DATA;
            ST_SRC_DATA: begin
                n_state = (r_cmd.command == CMD_MOVE && !w_rd_zero) ? ST_DST_DATA : ST_FIN;
            end
            ST_DST_DATA: n_state = ST_MV_WA;
            ST_MV_WA: n_state = ST_FIN;
            ST_CP_SCAN: begin
                if (!r_dv && r_end) n_state = ST_CP_ZERO;
            end
            ST_CP_ZERO: begin
                if (r_wend) n_state = ST_FIN;
            end
            ST_CLR: begin
                if (r_lin == LAST_ADDR) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd  = r_cmd;
        n_res  = r_res;
        n_row  = r_row;
        n_col  = r_col;
        n_end  = r_end;
        n_dv   = 1'b0;
        n_prow = r_prow;
        n_pcol = r_pcol;
        n_wrow = r_wrow;
        n_wcol = r_wcol;
        n_wend = r_wend;
        n_lin  = r_lin;
        n_va   = r_va;
        o_mem_we    = 1'b0;
        o_mem_waddr = slot_addr(r_prow, r_pcol);
        o_mem_wdata = '0;
        o_mem_raddr = slot_addr(r_row, r_col);
        o_busy      = (r_state != ST_IDLE);
        o_res_valid = (r_state == ST_FIN);

        // sweeping states issue one read per cycle at the cursor
        if ((r_state == ST_ADD || r_state == ST_CP_SCAN) && !r_end) begin
            n_dv   = 1'b1;
            n_prow = r_row;
            n_pcol = r_col;
            if (w_rcol_wrap) begin
                if (w_rrow_last) begin
                    n_end = 1'b1;
                end else begin
                    n_col = '0;
                    n_row = r_row + 4'd1;
                end
            end else begin
                n_col = r_col + 4'd1;
            end
        end

        case (r_state)
            ST_INIT, ST_CLR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_lin;
                n_lin       = r_lin + 1'b1;
                if (r_state == ST_CLR && r_lin == LAST_ADDR) n_res.ok = 1'b1;
            end
            ST_IDLE: begin
                if (i_req_valid) n_cmd = i_req;
                n_res  = '0;
                n_row  = '0;
                n_col  = '0;
                n_end  = 1'b0;
                n_wrow = '0;
                n_wcol = '0;
                n_wend = 1'b0;
                n_lin  = '0;
            end
            ST_ADD: begin
                if (r_dv && w_rd_zero && w_h != '0) begin
                    o_mem_we       = 1'b1;
                    o_mem_wdata    = w_h;
                    n_res.ok       = 1'b1;
                    n_res.slot_row = r_prow[POS_W-1:0];
                    n_res.slot_col = r_pcol[POS_W-1:0];
                end
            end
            ST_SRC: begin
                o_mem_raddr = slot_addr({1'b0, r_cmd.src_row}, {1'b0, r_cmd.src_col});
            end
            ST_SRC_DATA: begin
                o_mem_waddr = slot_addr({1'b0, r_cmd.src_row}, {1'b0, r_cmd.src_col});
                o_mem_raddr = slot_addr({1'b0, r_cmd.dst_row}, {1'b0, r_cmd.dst_col});
                if (!w_rd_zero) begin
                    if (r_cmd.command == CMD_MOVE) begin
                        n_va = i_mem_rdata;
                    end else begin
                        n_res.ok          = 1'b1;
                        n_res.slot_handle = HANDLE_W'({{HANDLE_W{1'b0}}, i_mem_rdata});
                        o_mem_we          = (r_cmd.command == CMD_REMOVE);
                    end
                end
            end
            ST_DST_DATA: begin
                // write the source item to the destination, keep the old one
                o_mem_we    = 1'b1;
                o_mem_waddr = slot_addr({1'b0, r_cmd.dst_row}, {1'b0, r_cmd.dst_col});
                o_mem_wdata = r_va;
                n_va        = i_mem_rdata;
            end
            ST_MV_WA: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = slot_addr({1'b0, r_cmd.src_row}, {1'b0, r_cmd.src_col});
                o_mem_wdata = r_va;
                n_res.ok    = 1'b1;
            end
            ST_CP_SCAN, ST_CP_ZERO: begin
                // write cursor trails the read cursor, so packing is in place
                o_mem_waddr = slot_addr(r_wrow, r_wcol);
                if (r_state == ST_CP_SCAN) begin
                    o_mem_we    = r_dv && !w_rd_zero;
                    o_mem_wdata = i_mem_rdata;
                end else begin
                    o_mem_we = !r_wend;
                    if (r_wend) n_res.ok = 1'b1;
                end
                if (o_mem_we) begin
                    if (w_wcol_wrap) begin
                        if (w_wrow_last) begin
                            n_wend = 1'b1;
                        end else begin
                            n_wcol = '0;
                            n_wrow = r_wrow + 4'd1;
                        end
                    end else begin
                        n_wcol = r_wcol + 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_lin   <= '0;
            r_dv    <= 1'b0;
            r_end   <= 1'b0;
            r_wend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lin   <= n_lin;
            r_dv    <= n_dv;
            r_end   <= n_end;
            r_wend  <= n_wend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_row  <= n_row;
        r_col  <= n_col;
        r_prow <= n_prow;
        r_pcol <= n_pcol;
        r_wrow <= n_wrow;
        r_wcol <= n_wcol;
        r_va   <= n_va;
    end

    assign o_res = r_res;

endmodule

// ===== tb/sv/tb_slot_grid_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_grid_table: self-checking bench for the slot grid table
// Drives add/remove/move/compact/read/clear requests under varying area
// settings and idling, predicts every result from a local copy of the grid,
// and compares each returned result field by field in request order.
// ----------------------------------------------------------------------------
module tb_slot_grid_table;
    import sgt_pkg::*;

    localparam int GRID_ROWS  = DEF_MAX_ROWS;
    localparam int GRID_COLS  = DEF_MAX_COLS;
    localparam int GRID_SLOTS = GRID_ROWS * GRID_COLS;
    localparam int SEG_ITEMS  = 50;
    // codes the block does not define; they must answer not-ok
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ROWS;
    logic [GEOM_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_command = CMD_READ;
    logic [HANDLE_W-1:0]  i_handle = '0;
    logic [POS_W-1:0]     i_src_row = '0;
    logic [POS_W-1:0]     i_src_col = '0;
    logic [POS_W-1:0]     i_dst_row = '0;
    logic [POS_W-1:0]     i_dst_col = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_ok;
    logic [POS_W-1:0]     o_slot_row;
    logic [POS_W-1:0]     o_slot_col;
    logic [HANDLE_W-1:0]  o_slot_handle;

    slot_grid_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_handle     (i_handle),
        .i_src_row    (i_src_row),
        .i_src_col    (i_src_col),
        .i_dst_row    (i_dst_row),
        .i_dst_col    (i_dst_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ok         (o_ok),
        .o_slot_row   (o_slot_row),
        .o_slot_col   (o_slot_col),
        .o_slot_handle(o_slot_handle)
    );

    // local copy of the grid and the area registers
    logic [HANDLE_W-1:0] grid_copy [GRID_SLOTS] = '{default: '0};
    logic [GEOM_W-1:0]   rows_reg = ROWS_RST;
    logic [GEOM_W-1:0]   cols_reg = COLS_RST;

    t_res expected_results[$];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int area_settings   = 0;
    int full_adds       = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // grid predictor
    // ------------------------------------------------------------------
    function automatic int active_span(input logic [GEOM_W-1:0] raw, input int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    function automatic bit in_active(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
        return r < active_span(rows_reg, GRID_ROWS) && c < active_span(cols_reg, GRID_COLS);
    endfunction

    function automatic t_res predict_slot_result(input t_cmd req);
        t_res                res;
        int                  nr;
        int                  nc;
        int                  a;
        int                  b;
        int                  n;
        int                  k;
        bit                  placed;
        logic [HANDLE_W-1:0] swap_val;
        logic [HANDLE_W-1:0] gathered [GRID_SLOTS];

        res    = '0;
        nr     = active_span(rows_reg, GRID_ROWS);
        nc     = active_span(cols_reg, GRID_COLS);
        placed = 1'b0;
        n      = 0;
        k      = 0;
        case (req.command)
            CMD_ADD: begin
                if (req.handle != 0) begin
                    for (int r = 0; r < nr; r++) begin
                        for (int c = 0; c < nc; c++) begin
                            if (!placed && grid_copy[r * GRID_COLS + c] == 0) begin
                                grid_copy[r * GRID_COLS + c] = req.handle;
                                placed       = 1'b1;
                                res.ok       = 1'b1;
                                res.slot_row = POS_W'(r);
                                res.slot_col = POS_W'(c);
                            end
                        end
                    end
                end
            end
            CMD_REMOVE, CMD_READ: begin
                if (in_active(req.src_row, req.src_col)) begin
                    a = req.src_row * GRID_COLS + req.src_col;
                    if (grid_copy[a] != 0) begin
                        res.ok          = 1'b1;
                        res.slot_handle = grid_copy[a];
                        if (req.command == CMD_REMOVE) grid_copy[a] = '0;
                    end
                end
            end
            CMD_MOVE: begin
                if (in_active(req.src_row, req.src_col) && in_active(req.dst_row, req.dst_col))
                begin
                    a = req.src_row * GRID_COLS + req.src_col;
                    b = req.dst_row * GRID_COLS + req.dst_col;
                    if (grid_copy[a] != 0) begin
                        swap_val     = grid_copy[b];
                        grid_copy[b] = grid_copy[a];
                        grid_copy[a] = swap_val;
                        res.ok       = 1'b1;
                    end
                end
            end
            CMD_COMPACT: begin
                for (int r = 0; r < nr; r++) begin
                    for (int c = 0; c < nc; c++) begin
                        if (grid_copy[r * GRID_COLS + c] != 0) begin
                            gathered[n] = grid_copy[r * GRID_COLS + c];
                            n++;
                        end
                        grid_copy[r * GRID_COLS + c] = '0;
                    end
                end
                for (int r = 0; r < nr; r++) begin
                    for (int c = 0; c < nc; c++) begin
                        if (k < n) begin
                            grid_copy[r * GRID_COLS + c] = gathered[k];
                            k++;
                        end
                    end
                end
                res.ok = 1'b1;
            end
            CMD_CLEAR: begin
                grid_copy = '{default: '0};
                res.ok    = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic t_cmd make_request(input logic [CMD_W-1:0] cmd,
                                          input logic [HANDLE_W-1:0] handle,
                                          input logic [POS_W-1:0] sr, input logic [POS_W-1:0] sc,
                                          input logic [POS_W-1:0] dr, input logic [POS_W-1:0] dc);
        t_cmd req;
        req.command = cmd;
        req.handle  = handle;
        req.src_row = sr;
        req.src_col = sc;
        req.dst_row = dr;
        req.dst_col = dc;
        return req;
    endfunction

    task automatic send_request(input t_cmd req);
        int   gap;
        t_res want;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= req.command;
        i_handle   <= req.handle;
        i_src_row  <= req.src_row;
        i_src_col  <= req.src_col;
        i_dst_row  <= req.dst_row;
        i_dst_col  <= req.dst_col;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_slot_result(req);
        expected_results.insert(expected_results.size(), want);
        if (req.command == CMD_ADD && req.handle != 0 && !want.ok) full_adds++;
        requests_sent++;
    endtask

    // sender pauses until every pending result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // only called with the block idle
    task automatic set_geometry(input logic [GEOM_W-1:0] rows, input logic [GEOM_W-1:0] cols);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        rows_reg = rows;
        i_cfg_index <= CFG_COLS;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        cols_reg = cols;
        i_cfg_we <= 1'b0;
        area_settings++;
    endtask

    // mostly well-formed requests aimed at occupied slots, some noise
    function automatic t_cmd random_request();
        t_cmd req;
        int   nr;
        int   nc;
        int   roll;
        nr          = active_span(rows_reg, GRID_ROWS);
        nc          = active_span(cols_reg, GRID_COLS);
        req.handle  = HANDLE_W'($urandom_range(65535));
        req.src_row = POS_W'($urandom_range(7));
        req.src_col = POS_W'($urandom_range(7));
        req.dst_row = POS_W'($urandom_range(7));
        req.dst_col = POS_W'($urandom_range(7));
        roll = $urandom_range(19);
        if (roll == 0) req.handle = '0;
        else if (roll == 1) req.handle = '1;
        else if (req.handle == 0) req.handle = 16'h0001;
        if ($urandom_range(9) < 8) begin
            for (int k = 0; k < 8; k++) begin
                req.src_row = POS_W'($urandom_range(nr - 1));
                req.src_col = POS_W'($urandom_range(nc - 1));
                if (grid_copy[req.src_row * GRID_COLS + req.src_col] != 0) break;
            end
        end
        if ($urandom_range(99) < 85) begin
            req.dst_row = POS_W'($urandom_range(nr - 1));
            req.dst_col = POS_W'($urandom_range(nc - 1));
        end
        roll = $urandom_range(99);
        if (roll < 36)      req.command = CMD_ADD;
        else if (roll < 48) req.command = CMD_REMOVE;
        else if (roll < 63) req.command = CMD_MOVE;
        else if (roll < 70) req.command = CMD_COMPACT;
        else if (roll < 88) req.command = CMD_READ;
        else if (roll < 91) req.command = CMD_CLEAR;
        else if (roll < 95) req.command = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
        else begin
            req = $bits(t_cmd)'($urandom());
            req.handle = HANDLE_W'($urandom_range(65535));
        end
        return req;
    endfunction

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                   input logic [HANDLE_W-1:0] want);
        $display("MISMATCH at %0t, result %0d: %s got %h expected %h",
                 $realtime, results_checked, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, handle", o_slot_handle, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch("ok", HANDLE_W'(o_ok), HANDLE_W'(want.ok));
                if (o_slot_row !== want.slot_row)
                    report_mismatch("slot_row", HANDLE_W'(o_slot_row),
                                    HANDLE_W'(want.slot_row));
                if (o_slot_col !== want.slot_col)
                    report_mismatch("slot_col", HANDLE_W'(o_slot_col),
                                    HANDLE_W'(want.slot_col));
                if (o_slot_handle !== want.slot_handle)
                    report_mismatch("slot_handle", o_slot_handle, want.slot_handle);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // reset area is two rows by one column
        send_request(make_request(CMD_READ, 16'h0000, 0, 0, 0, 0));     // empty slot
        send_request(make_request(CMD_ADD, 16'h0000, 0, 0, 0, 0));      // zero handle rejected
        send_request(make_request(CMD_ADD, 16'hFFFF, 7, 7, 7, 7));
        send_request(make_request(CMD_ADD, 16'h0001, 0, 0, 0, 0));
        send_request(make_request(CMD_ADD, 16'h8000, 0, 0, 0, 0));      // area full
        send_request(make_request(CMD_READ, 16'h0000, 7, 7, 0, 0));     // out of range
        send_request(make_request(CMD_REMOVE, 16'h0000, 1, 7, 0, 0));   // column out of range
        send_request(make_request(CMD_MOVE, 16'h0000, 0, 0, 1, 0));     // swap
        send_request(make_request(CMD_MOVE, 16'h0000, 1, 0, 1, 0));     // onto itself
        send_request(make_request(CMD_MOVE, 16'h0000, 0, 0, 7, 0));     // dest out of range
        send_request(make_request(CMD_REMOVE, 16'h0000, 0, 0, 0, 0));
        send_request(make_request(CMD_MOVE, 16'h0000, 0, 0, 1, 0));     // empty source
        send_request(make_request(CMD_MOVE, 16'h0000, 1, 0, 0, 0));     // into empty slot
        send_request(make_request(CMD_COMPACT, 16'h0000, 0, 0, 0, 0));
        send_request(make_request(CMD_UNDEF_LO, 16'hFFFF, 7, 7, 7, 7));
        send_request(make_request(CMD_UNDEF_HI, 16'hFFFF, 0, 0, 0, 0));
        send_request(make_request(CMD_ADD, 16'hA5A5, 0, 0, 0, 0));
        wait_results_drained();
        // one row, and zero columns saturates to one: row 1 becomes hidden
        set_geometry(4'd1, 4'd0);
        send_request(make_request(CMD_ADD, 16'h5555, 0, 0, 0, 0));
        send_request(make_request(CMD_COMPACT, 16'h0000, 0, 0, 0, 0));
        send_request(make_request(CMD_READ, 16'h0000, 1, 0, 0, 0));
        wait_results_drained();
        // oversized values saturate to the full grid; hidden item shows again
        set_geometry(4'd15, 4'd15);
        send_request(make_request(CMD_READ, 16'h0000, 1, 0, 0, 0));
        send_request(make_request(CMD_ADD, 16'h7E7E, 0, 0, 0, 0));
        send_request(make_request(CMD_CLEAR, 16'h0000, 0, 0, 0, 0));
        send_request(make_request(CMD_READ, 16'h0000, 7, 7, 0, 0));
        wait_results_drained();
    endtask

    // receiver holds off while requests keep coming, then a full pause
    task automatic test_hold_off();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_geometry(4'd8, 4'd8);
        hold_request = 400;
        for (int i = 0; i < 40; i++) send_request(random_request());
        wait_results_drained();
    endtask

    task automatic test_idle_phase(input int idle_pct, input int stall_pct_v, input int items);
        int left;
        send_idle_pct = idle_pct;
        stall_pct     = stall_pct_v;
        left          = items;
        while (left > 0) begin
            wait_results_drained();
            case ($urandom_range(7))
                0:       set_geometry(4'd8, 4'd8);
                1:       set_geometry(GEOM_W'($urandom_range(15)),
                                      GEOM_W'($urandom_range(15)));
                2:       set_geometry(4'd1, 4'd1);
                default: set_geometry(GEOM_W'($urandom_range(1, 4)),
                                      GEOM_W'($urandom_range(1, 4)));
            endcase
            for (int i = 0; i < SEG_ITEMS && left > 0; i++) begin
                send_request(random_request());
                left--;
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_hold_off();
        test_idle_phase(0, 0, 410);
        test_idle_phase(87, 0, 410);
        test_idle_phase(0, 87, 410);
        test_idle_phase(22, 22, 410);

        wait_results_drained();
        // any late or spurious result shows up within one compact sweep
        repeat (2 * GRID_SLOTS + 8) @(posedge i_clk);

        $display("Run covered %0d requests over %0d area settings; %0d results checked",
                 requests_sent, area_settings, results_checked);
        $display("Adds refused on a full area: %0d; idling phases and a long hold-off included",
                 full_adds);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sgt_pkg.sv
rtl/sgt_ram.sv
rtl/sgt_ctrl.sv
rtl/slot_grid_table.sv
tb/sv/tb_slot_grid_table.sv
